### src/sesa_pkg.sv
package sesa_pkg;

  localparam int DataW = 64;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;
  localparam logic [2:0] OP_NEG = 3'd5;

  localparam logic [1:0] W_8  = 2'd0;
  localparam logic [1:0] W_16 = 2'd1;
  localparam logic [1:0] W_32 = 2'd2;
  localparam logic [1:0] W_64 = 2'd3;

  typedef enum logic [1:0] {
    K_DIRECT = 2'd0,
    K_MUL    = 2'd1,
    K_DIV    = 2'd2,
    K_REM    = 2'd3
  } kind_t;

  // For direct kinds, ua already holds the finished result.
  typedef struct packed {
    kind_t            kind;
    logic             err;
    logic             neg;
    logic [1:0]       wsel;
    logic [DataW-1:0] ua;
    logic [DataW-1:0] ub;
  } item_t;

  function automatic logic [DataW-1:0] top_of(input logic [1:0] wsel);
    logic [DataW-1:0] t;
    case (wsel)
      W_8:     t = 64'h0000_0000_0000_0080;
      W_16:    t = 64'h0000_0000_0000_8000;
      W_32:    t = 64'h0000_0000_8000_0000;
      W_64:    t = 64'h8000_0000_0000_0000;
      default: t = 64'h8000_0000_0000_0000;
    endcase
    return t;
  endfunction

  function automatic logic [DataW-1:0] marker_of(input logic [1:0] wsel);
    return DataW'(0) - top_of(wsel);
  endfunction

endpackage

### src/sesa_front.sv
module sesa_front (
  input  logic [2:0]         operation,
  input  logic [1:0]         width_sel,
  input  logic signed [63:0] left_operand,
  input  logic signed [63:0] right_operand,
  output sesa_pkg::item_t    item
);

  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] top;
  logic [63:0] marker;
  logic [63:0] sum;
  logic [63:0] diff;
  logic        a_mark;
  logic        b_mark;

  always_comb begin
    case (width_sel)
      sesa_pkg::W_8: begin
        a = {{56{left_operand[7]}}, left_operand[7:0]};
        b = {{56{right_operand[7]}}, right_operand[7:0]};
      end
      sesa_pkg::W_16: begin
        a = {{48{left_operand[15]}}, left_operand[15:0]};
        b = {{48{right_operand[15]}}, right_operand[15:0]};
      end
      sesa_pkg::W_32: begin
        a = {{32{left_operand[31]}}, left_operand[31:0]};
        b = {{32{right_operand[31]}}, right_operand[31:0]};
      end
      default: begin
        a = left_operand;
        b = right_operand;
      end
    endcase
  end

  assign top    = sesa_pkg::top_of(width_sel);
  assign marker = sesa_pkg::marker_of(width_sel);
  assign a_mark = (a == marker);
  assign b_mark = (b == marker);
  assign sum    = a + b;
  assign diff   = a - b;

  always_comb begin
    item.wsel = width_sel;
    item.ua   = a[63] ? 64'd0 - a : a;
    item.ub   = b[63] ? 64'd0 - b : b;
    item.neg  = 1'b0;
    item.kind = sesa_pkg::K_DIRECT;
    item.err  = 1'b1;
    case (operation)
      sesa_pkg::OP_ADD: begin
        item.ua  = sum;
        item.err = a_mark || b_mark || (|((a ^ sum) & (b ^ sum) & top));
      end
      sesa_pkg::OP_SUB: begin
        item.ua  = diff;
        item.err = a_mark || b_mark || (|((a ^ b) & (a ^ diff) & top));
      end
      sesa_pkg::OP_NEG: begin
        item.ua  = 64'd0 - a;
        item.err = a_mark;
      end
      sesa_pkg::OP_MUL: begin
        item.kind = sesa_pkg::K_MUL;
        item.neg  = a[63] ^ b[63];
        item.err  = a_mark || b_mark;
      end
      sesa_pkg::OP_DIV: begin
        item.kind = sesa_pkg::K_DIV;
        item.neg  = a[63] ^ b[63];
        item.err  = a_mark || b_mark || (b == 64'd0);
      end
      sesa_pkg::OP_REM: begin
        item.kind = sesa_pkg::K_REM;
        item.neg  = a[63];
        item.err  = a_mark || b_mark || (b == 64'd0);
      end
      default: begin
        item.ua  = 64'd0;
        item.err = 1'b1;
      end
    endcase
  end

endmodule

### src/sesa_fifo.sv
module sesa_fifo #(
  parameter int Depth = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sesa_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output sesa_pkg::item_t head
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  sesa_pkg::item_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/sesa_back.sv
module sesa_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  sesa_pkg::item_t    head,
  output logic               head_pop,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [63:0] result_value,
  output logic               is_error
);

  localparam int Steps = 64;

  typedef struct packed {
    sesa_pkg::kind_t kind;
    logic            err;
    logic            neg;
    logic [1:0]      wsel;
    logic [63:0]     rem;
    logic [63:0]     quo;
    logic [63:0]     dvs;
  } stage_t;

  function automatic stage_t div_step(input stage_t s);
    stage_t      n;
    logic [64:0] t;
    logic        qb;
    n = s;
    if (s.kind == sesa_pkg::K_DIV || s.kind == sesa_pkg::K_REM) begin
      t  = {s.rem, s.quo[63]};
      qb = (t >= {1'b0, s.dvs});
      if (qb) begin
        t = t - {1'b0, s.dvs};
      end
      n.rem = t[63:0];
      n.quo = {s.quo[62:0], qb};
    end
    return n;
  endfunction

  stage_t      st   [Steps];
  logic        st_v [Steps];
  stage_t      init;
  logic        en;

  logic [63:0] pp_ll;
  logic [63:0] pp_lh;
  logic [63:0] pp_hl;
  logic [63:0] pp_hh;
  logic [64:0] mid;
  logic [63:0] sum_ll;
  logic [63:0] sum_hh;
  logic [127:0] prod;
  logic [63:0] maxv;
  stage_t      mul_fix;

  logic [63:0] fin_mag;
  logic [63:0] fin_val;
  logic [63:0] fin_marker;

  assign en       = !result_valid || result_ready;
  assign head_pop = en && head_valid;

  always_comb begin
    init.kind = head.kind;
    init.err  = head.err;
    init.neg  = head.neg;
    init.wsel = head.wsel;
    init.rem  = 64'd0;
    init.quo  = head.ua;
    init.dvs  = head.ub;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll  <= 64'(head.ua[31:0] * head.ub[31:0]);
      pp_lh  <= 64'(head.ua[31:0] * head.ub[63:32]);
      pp_hl  <= 64'(head.ua[63:32] * head.ub[31:0]);
      pp_hh  <= 64'(head.ua[63:32] * head.ub[63:32]);
      mid    <= {1'b0, pp_lh} + {1'b0, pp_hl};
      sum_ll <= pp_ll;
      sum_hh <= pp_hh;
    end
  end

  assign prod = {sum_hh, sum_ll} + {31'd0, mid, 32'd0};
  assign maxv = sesa_pkg::top_of(st[1].wsel) - 64'd1;

  always_comb begin
    mul_fix = div_step(st[1]);
    if (st[1].kind == sesa_pkg::K_MUL) begin
      mul_fix.quo = prod[63:0];
      mul_fix.err = st[1].err || (|(prod & ~{64'd0, maxv}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_step(init);
      st[1] <= div_step(st[0]);
      st[2] <= mul_fix;
    end
  end

  for (genvar j = 3; j < Steps; j++) begin : g_steps
    always_ff @(posedge clk) begin
      if (en) begin
        st[j] <= div_step(st[j-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Steps; k++) begin
        st_v[k] <= 1'b0;
      end
      result_valid <= 1'b0;
    end else if (en) begin
      st_v[0] <= head_valid;
      for (int k = 1; k < Steps; k++) begin
        st_v[k] <= st_v[k-1];
      end
      result_valid <= st_v[Steps-1];
    end
  end

  assign fin_mag    = (st[Steps-1].kind == sesa_pkg::K_REM) ? st[Steps-1].rem
                                                            : st[Steps-1].quo;
  assign fin_val    = st[Steps-1].neg ? 64'd0 - fin_mag : fin_mag;
  assign fin_marker = sesa_pkg::marker_of(st[Steps-1].wsel);

  always_ff @(posedge clk) begin
    if (en) begin
      if (st[Steps-1].err || fin_val == fin_marker) begin
        result_value <= fin_marker;
        is_error     <= 1'b1;
      end else begin
        result_value <= fin_val;
        is_error     <= 1'b0;
      end
    end
  end

endmodule

### src/sticky_error_signed_alu_top.sv
// One input beat is accepted every cycle when the output is not stalled.
// The pipeline depth is set by the 64 pipelined restoring-divide stages, which every operation passes.
// Reset clears the queue and all stage valid bits; payload registers are not reset.
module sticky_error_signed_alu_top #(
  parameter int QueueDepth = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [2:0]         operation,
  input  logic [1:0]         width_sel,
  input  logic signed [63:0] left_operand,
  input  logic signed [63:0] right_operand,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [63:0] result_value,
  output logic               is_error
);

  sesa_pkg::item_t front_item;
  sesa_pkg::item_t head;
  logic            full;
  logic            not_empty;
  logic            pop;

  assign item_ready = !full;

  sesa_front u_front (
    .operation     (operation),
    .width_sel     (width_sel),
    .left_operand  (left_operand),
    .right_operand (right_operand),
    .item          (front_item)
  );

  sesa_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid),
    .push_item (front_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  sesa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (not_empty),
    .head         (head),
    .head_pop     (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_value (result_value),
    .is_error     (is_error)
  );

endmodule

### test/sticky_error_signed_alu_top_test.sv
`timescale 1ns / 1ps
module sticky_error_signed_alu_top_test;

  typedef struct {
    logic [2:0]  op;
    logic [1:0]  wsel;
    logic [63:0] lhs;
    logic [63:0] rhs;
  } alu_beat_t;

  typedef struct {
    logic [63:0] value;
    logic        err;
  } alu_result_t;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic [2:0] operation = '0;
  logic [1:0] width_sel = '0;
  logic signed [63:0] left_operand = '0;
  logic signed [63:0] right_operand = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [63:0] result_value;
  logic is_error;

  alu_beat_t   pending_beats[$];
  alu_result_t expected_results[$];
  int mismatches = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int errors_seen = 0;
  bit quiet_phase = 1'b0;
  bit hold_sender = 1'b0;
  bit timed_out = 1'b0;

  sticky_error_signed_alu_top i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .operation(operation), .width_sel(width_sel),
    .left_operand(left_operand), .right_operand(right_operand),
    .result_valid(result_valid), .result_ready(result_ready),
    .result_value(result_value), .is_error(is_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic alu_result_t compute_alu(alu_beat_t b);
    alu_result_t res;
    logic [63:0] top, mask, marker, maxv, a, c, raw, ovf, ua, ub, r, q;
    logic aneg, bneg, err;
    int w;
    w = 8 << b.wsel;
    top = 64'd1 << (w - 1);
    mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    marker = 64'd0 - top;
    maxv = top - 64'd1;
    a = ((b.lhs & mask) ^ top) - top;
    c = ((b.rhs & mask) ^ top) - top;
    aneg = a[63];
    bneg = c[63];
    ua = aneg ? 64'd0 - a : a;
    ub = bneg ? 64'd0 - c : c;
    err = 1'b0;
    r = '0;
    case (b.op)
      sesa_pkg::OP_ADD, sesa_pkg::OP_SUB: begin
        err = (a == marker) || (c == marker);
        if (b.op == sesa_pkg::OP_ADD) begin
          raw = a + c;
          ovf = (a ^ raw) & (c ^ raw);
        end else begin
          raw = a - c;
          ovf = (a ^ c) & (a ^ raw);
        end
        if ((ovf & top) != 0) err = 1'b1;
        r = ((raw & mask) ^ top) - top;
      end
      sesa_pkg::OP_MUL: begin
        err = (a == marker) || (c == marker);
        if (!err) begin
          if (ua != 0 && ub > maxv / ua) err = 1'b1;
          else begin
            q = ua * ub;
            r = (aneg != bneg) ? 64'd0 - q : q;
          end
        end
      end
      sesa_pkg::OP_DIV, sesa_pkg::OP_REM: begin
        err = (a == marker) || (c == marker) || (c == 0);
        if (!err) begin
          if (b.op == sesa_pkg::OP_DIV) begin
            q = ua / ub;
            r = (aneg != bneg) ? 64'd0 - q : q;
          end else begin
            q = ua % ub;
            r = aneg ? 64'd0 - q : q;
          end
        end
      end
      sesa_pkg::OP_NEG: begin
        err = (a == marker);
        if (!err) r = 64'd0 - a;
      end
      default: err = 1'b1;
    endcase
    if (r == marker) err = 1'b1;
    if (err) r = marker;
    res.value = r;
    res.err = err;
    return res;
  endfunction

  function automatic logic [63:0] random_operand(logic [1:0] wsel);
    logic [63:0] v;
    int w;
    w = 8 << wsel;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'd0 - (64'd1 << (w - 1));
      1: v = (64'd1 << (w - 1)) - 64'd1;
      2: v = '1;
      3: v = 64'd0;
      4: v = 64'($urandom_range(0, 20));
      5: v = 64'd0 - 64'($urandom_range(1, 20));
      6: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_beat(logic [2:0] op, logic [1:0] wsel, logic [63:0] lhs,
                          logic [63:0] rhs);
    alu_beat_t b;
    b.op = op;
    b.wsel = wsel;
    b.lhs = lhs;
    b.rhs = rhs;
    pending_beats.push_back(b);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        expected_results.push_back(compute_alu('{operation, width_sel, left_operand,
                                                 right_operand}));
        beats_sent++;
      end
      if ((!item_valid || item_ready) && !hold_sender && pending_beats.size() != 0 &&
          (quiet_phase || $urandom_range(0, 99) >= 19)) begin
        alu_beat_t b;
        b = pending_beats.pop_front();
        item_valid <= 1'b1;
        operation <= b.op;
        width_sel <= b.wsel;
        left_operand <= b.lhs;
        right_operand <= b.rhs;
      end else if (item_valid && item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    alu_result_t exp_res;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (is_error) errors_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result beat: value %h error %b", result_value, is_error);
        end else begin
          exp_res = expected_results.pop_front();
          if (result_value !== exp_res.value || is_error !== exp_res.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %h/%b, got %h/%b", exp_res.value, exp_res.err,
                       result_value, is_error);
          end
        end
      end
      result_ready <= quiet_phase || ($urandom_range(0, 99) >= 19);
      if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Watchdog expired with %0d results outstanding.", expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [1:0] wsel;
    logic [63:0] mn;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int ws = 0; ws < 4; ws++) begin
      wsel = ws[1:0];
      mn = 64'd0 - (64'd1 << ((8 << ws) - 1));
      add_beat(sesa_pkg::OP_ADD, wsel, mn - 64'd1, 64'd1);
      add_beat(sesa_pkg::OP_SUB, wsel, mn, 64'd0);
      add_beat(sesa_pkg::OP_MUL, wsel, ~mn, 64'd2);
      add_beat(sesa_pkg::OP_DIV, wsel, mn + 64'd1, '1);
      add_beat(sesa_pkg::OP_REM, wsel, mn, '1);
      add_beat(sesa_pkg::OP_NEG, wsel, mn, mn);
    end
    add_beat(sesa_pkg::OP_DIV, sesa_pkg::W_32, 64'd7, 64'd0);
    add_beat(sesa_pkg::OP_REM, sesa_pkg::W_16, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
    add_beat(3'd6, sesa_pkg::W_8, 64'd1, 64'd1);
    add_beat(3'd7, sesa_pkg::W_64, 64'd1, 64'd1);
    add_beat(sesa_pkg::OP_ADD, sesa_pkg::W_8, 64'hFFFF_FFFF_FFFF_FF05,
             64'hAAAA_AAAA_AAAA_AA03);

    while (pending_beats.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
    hold_sender = 1'b0;

    for (int i = 0; i < 850; i++) begin
      wsel = 2'($urandom_range(0, 3));
      add_beat(3'(($urandom_range(0, 19) == 0) ? $urandom_range(6, 7)
                                                : $urandom_range(0, 5)),
               wsel, random_operand(wsel), random_operand(wsel));
      if (i == 300) begin
        while (pending_beats.size() != 0) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_results.size() != 0 || item_valid) @(posedge clk);
        hold_sender = 1'b0;
        quiet_phase = 1'b1;
      end
      if (i == 500) begin
        while (pending_beats.size() != 0) @(posedge clk);
        quiet_phase = 1'b0;
      end
    end

    while (pending_beats.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d operation beats over all widths and operations; %0d results checked,",
             beats_sent, results_seen);
    $display("%0d of them error markers, %0d mismatches.", errors_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
src/sesa_pkg.sv
src/sesa_front.sv
src/sesa_fifo.sv
src/sesa_back.sv
src/sticky_error_signed_alu_top.sv
test/sticky_error_signed_alu_top_test.sv
